[hdl/hrir_fir_convolver_core_macros.svh]
// ----------------------------------------------------------------------------
// hrir_fir_convolver_core_macros.svh
// Assertion shorthands shared by the HRIR convolver RTL.
// ----------------------------------------------------------------------------
`ifndef HRIR_FIR_CONVOLVER_CORE_MACROS_SVH
`define HRIR_FIR_CONVOLVER_CORE_MACROS_SVH

// Property checked on every clock, masked while reset is high.
`define HFC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle, masked while reset is high.
`define HFC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/hrirfir_pkg.sv]
// ----------------------------------------------------------------------------
// hrirfir_pkg
// Shared types and codes of the HRIR FIR convolver.
// ----------------------------------------------------------------------------
package hrirfir_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TAP    = 1'b1;

  // Width of the tap index field of a request
  localparam int TAP_IDX_BITS = 8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[hdl/hrir_fir_convolver_core.sv]
// A sample request passes the registered memory reads, the product register and the
//   accumulator, then the output register. The single shared MAC steps through every tap
//   before the next request is taken; tap writes are taken back to back while idle.
// The result sits in an output register, so the next request can start while it waits.
// Reset (rst, sync, active high) clears the sequencer, the output valid and the
//   delay line fill count; tap memory holds garbage until written.
// ----------------------------------------------------------------------------
// hrir_fir_convolver_core
// Direct-form FIR over a ring-buffer delay line and a tap memory, evaluated
// one tap per cycle on a single multiply-accumulate unit.
// ----------------------------------------------------------------------------
`include "hrir_fir_convolver_core_macros.svh"

module hrir_fir_convolver_core #(
  parameter int NUM_TAPS    = 200,
  parameter int SAMPLE_BITS = 16,
  parameter int COEF_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  // tdata: sample_in, tap_index, tap_value (low to high), zero padded
  input  logic [((SAMPLE_BITS + hrirfir_pkg::TAP_IDX_BITS + COEF_BITS + 7) / 8) * 8 - 1:0]
               s_axis_tdata,
  // tuser: mode
  input  logic s_axis_tuser,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: sample_out, zero padded
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: out_of_range
  output logic m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready
);
  import hrirfir_pkg::*;

  localparam int IDX_W    = $clog2(NUM_TAPS);
  localparam int CNT_W    = $clog2(NUM_TAPS + 1);
  localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PROD_W   = SAMPLE_BITS + COEF_BITS;
  localparam int FULL_W   = PROD_W + IDX_W;
  localparam int ACC_W    = (FULL_W > 64) ? 64 : FULL_W;
  localparam int FRAC_W   = SAMPLE_BITS + COEF_BITS - 2;
  localparam int TIDX_LO  = SAMPLE_BITS;
  localparam int TVAL_LO  = SAMPLE_BITS + TAP_IDX_BITS;

  localparam logic signed [ACC_W-1:0] ACC_ONE     = ACC_W'(1) << FRAC_W;
  localparam logic signed [ACC_W-1:0] ACC_NEG_ONE = -ACC_ONE;
  localparam logic [IDX_W-1:0]        LAST_IDX    = IDX_W'(NUM_TAPS - 1);
  localparam logic [CNT_W-1:0]        FULL_CNT    = CNT_W'(NUM_TAPS);

  // Storage
  logic signed [SAMPLE_BITS-1:0] dl_mem   [NUM_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [NUM_TAPS];

  state_t state, state_next;

  logic [IDX_W-1:0]  head;       // slot of newest sample
  logic [IDX_W-1:0]  rd_ptr;     // delay line slot for current tap
  logic [IDX_W-1:0]  k;          // current tap
  logic [CNT_W-1:0]  cnt;        // samples seen, saturating

  logic                          p1;
  logic                          p2;
  logic                          tap_ok_q;
  logic signed [SAMPLE_BITS-1:0] samp_q;
  logic signed [COEF_BITS-1:0]   coef_q;
  logic signed [SAMPLE_BITS-1:0] samp_gated;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_shr;

  logic                          in_req;
  logic                          issue;
  logic                          out_free;
  logic                          load_out;
  logic [IDX_W-1:0]              head_inc;
  logic [TAP_IDX_BITS-1:0]       wr_tap;
  logic [IDX_W-1:0]              wr_idx;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [COEF_BITS-1:0]   in_coef;
  logic [SAMPLE_BITS-1:0]        res_data;
  logic                          res_oor;

  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign wr_tap    = s_axis_tdata[TVAL_LO-1:TIDX_LO];
  assign wr_idx    = IDX_W'(wr_tap);
  assign in_coef   = s_axis_tdata[TVAL_LO+COEF_BITS-1:TVAL_LO];
  assign in_req    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign head_inc  = (head == LAST_IDX) ? '0 : head + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_req && s_axis_tuser == MODE_SAMPLE) state_next = ST_MAC;
      end
      ST_MAC: begin
        if (k == LAST_IDX) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!p1 && !p2) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_MAC:   issue         = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_out      = out_free;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= LAST_IDX;
      cnt   <= '0;
      p1    <= 1'b0;
      p2    <= 1'b0;
    end else begin
      state <= state_next;
      p1    <= issue;
      p2    <= p1;
      if (in_req && s_axis_tuser == MODE_SAMPLE) begin
        head <= head_inc;
        if (cnt != FULL_CNT) cnt <= cnt + 1'b1;
      end
    end
  end

  // Tap and ring pointer stepping
  always_ff @(posedge clk) begin
    if (in_req && s_axis_tuser == MODE_SAMPLE) begin
      k      <= '0;
      rd_ptr <= head_inc;
    end else if (issue) begin
      k      <= k + 1'b1;
      rd_ptr <= (rd_ptr == '0) ? LAST_IDX : rd_ptr - 1'b1;
    end
  end

  // Delay line write and registered read
  always_ff @(posedge clk) begin
    if (in_req && s_axis_tuser == MODE_SAMPLE) dl_mem[head_inc] <= in_sample;
    samp_q <= dl_mem[rd_ptr];
  end

  // Tap memory write and registered read; indexes past the last tap are dropped
  always_ff @(posedge clk) begin
    if (in_req && s_axis_tuser == MODE_TAP && int'(wr_tap) < NUM_TAPS) begin
      coef_mem[wr_idx] <= in_coef;
    end
    coef_q <= coef_mem[k];
  end

  // Slots not yet filled since reset read as zero
  always_ff @(posedge clk) begin
    tap_ok_q <= CNT_W'(k) < cnt;
  end

  assign samp_gated = tap_ok_q ? samp_q : '0;

  // Multiply, then accumulate
  always_ff @(posedge clk) begin
    prod <= coef_q * samp_gated;
    if (in_req && s_axis_tuser == MODE_SAMPLE) begin
      acc <= '0;
    end else if (p2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Range check, truncation toward minus infinity, saturation at +1.0
  assign acc_shr = acc >>> (COEF_BITS - 1);
  always_comb begin
    res_oor  = (acc > ACC_ONE) || (acc < ACC_NEG_ONE);
    res_data = acc_shr[SAMPLE_BITS-1:0];
    if (res_oor) begin
      res_data = '0;
    end else if (acc == ACC_ONE) begin
      res_data = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= OUT_W'(res_data);
      m_axis_tuser <= res_oor;
    end
  end

  // Checks
  `HFC_ASSERT_NEXT(a_sample_starts_mac, in_req && s_axis_tuser == MODE_SAMPLE,
                   state == ST_MAC && k == '0, "sample request did not start the MAC")
  `HFC_ASSERT_NEXT(a_tap_write_stays_idle, in_req && s_axis_tuser == MODE_TAP,
                   state == ST_IDLE, "tap write left the idle state")
  `HFC_ASSERT(a_cnt_bounded, cnt <= FULL_CNT, "fill count past the tap count")
  `HFC_ASSERT(a_pipe_empty_idle, state != ST_IDLE || (!p1 && !p2),
              "MAC pipeline busy while idle")
  `HFC_ASSERT(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state) == ST_DONE,
              "result raised outside the done state")

endmodule

[dv/tb_hrir_fir_convolver_core.sv]
// ----------------------------------------------------------------------------
// tb_hrir_fir_convolver_core
// Self-checking bench for the 200-tap HRIR FIR convolver. Sample and tap-write
// requests go in over the input stream with random gaps. The output stream is
// stalled at random. Each filtered sample is checked against a bit-true model
// of the delay line, the tap memory and the Q1.15 range/truncation rules.
// ----------------------------------------------------------------------------
module tb_hrir_fir_convolver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import hrirfir_pkg::*;

  localparam int NUM_TAPS = 200;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int IN_W     = ((SAMPLE_W + $clog2(NUM_TAPS) + COEF_W + 7) / 8) * 8;
  localparam int OUT_W    = ((SAMPLE_W + 7) / 8) * 8;
  // 1.0 in the Q2.30 product domain
  localparam longint UNITY = longint'(1) << (SAMPLE_W + COEF_W - 2);
  localparam longint SAT_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;

  // Tap sets used by the random phases
  typedef enum int {
    PROF_FULL,
    PROF_SOFT,
    PROF_SPARSE
  } tap_profile_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] tap_value;
    logic [7:0]  tap_index;
    logic [15:0] sample_in;
  } fir_req_t;

  typedef struct packed {
    logic        out_of_range;
    logic [15:0] sample_out;
  } fir_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  // tdata: sample_in, tap_index, tap_value (low to high)
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  // tuser: mode
  logic             s_axis_tuser  = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // tdata: sample_out
  logic [OUT_W-1:0] m_axis_tdata;
  // tuser: out_of_range
  logic             m_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;

  hrir_fir_convolver_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fir_req_t    pending_reqs[$];
  fir_res_t    expected_outs[$];
  fir_req_t    drv_req;
  logic        took_req = 1'b0;
  int          err_count = 0;

  // Model state: tap memory and delay line (newest sample at index 0)
  logic [15:0] coef_mem [NUM_TAPS];
  logic [15:0] hist [NUM_TAPS];
  int          coef_bound;

  // Advance the filter model by one request; sample requests queue a result
  function automatic void apply_request(input fir_req_t r);
    longint   acc;
    longint   q;
    fir_res_t res;
    if (r.mode == MODE_TAP) begin
      if (r.tap_index < NUM_TAPS) coef_mem[r.tap_index] = r.tap_value;
    end else begin
      for (int k = NUM_TAPS - 1; k > 0; k--) hist[k] = hist[k - 1];
      hist[0] = r.sample_in;
      acc = 0;
      for (int k = 0; k < NUM_TAPS; k++)
        acc += longint'($signed(coef_mem[k])) * longint'($signed(hist[k]));
      if (acc > UNITY || acc < -UNITY) begin
        res.out_of_range = 1'b1;
        res.sample_out   = '0;
      end else begin
        // arithmetic shift floors, so +1.0 lands one past the max and saturates
        q = acc >>> (COEF_W - 1);
        if (q > SAT_MAX) q = SAT_MAX;
        res.out_of_range = 1'b0;
        res.sample_out   = q[15:0];
      end
      expected_outs.push_back(res);
    end
  endfunction

  task automatic push_tap(input int idx, input logic [15:0] val);
    fir_req_t r;
    r.mode      = MODE_TAP;
    r.tap_index = idx[7:0];
    r.tap_value = val;
    r.sample_in = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic push_sample(input logic [15:0] val);
    fir_req_t r;
    r.mode      = MODE_SAMPLE;
    r.sample_in = val;
    r.tap_index = 8'($urandom);
    r.tap_value = 16'($urandom);
    pending_reqs.push_back(r);
  endtask

  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 16'h8000;
        1: v = 16'h7FFF;
        2: v = 16'h0000;
        default: v = 16'hFFFF;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] rand_coef(input tap_profile_t prof);
    int v;
    v = 0;
    case (prof)
      PROF_FULL: v = int'(16'($urandom));
      PROF_SOFT: v = int'($urandom_range(0, 2 * coef_bound)) - coef_bound;
      default: begin
        if ($urandom_range(0, 9) == 0) v = int'(16'($urandom));
      end
    endcase
    return 16'(v);
  endfunction

  // Sender gaps: mostly none or short, a few long, with gap-free stretches
  int send_calm = 0;
  function automatic int next_send_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    if (roll < 2) begin
      send_calm = $urandom_range(30, 150);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input driver
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || took_req)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        drv_req = pending_reqs.pop_front();
        s_axis_tuser  <= drv_req.mode;
        s_axis_tdata  <= {drv_req.tap_value, drv_req.tap_index, drv_req.sample_in};
        s_axis_tvalid <= 1'b1;
        gap_left = next_send_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output backpressure
  int stall_left = 0;
  int recv_calm  = 0;
  always @(negedge clk) begin
    int roll;
    roll = $urandom_range(0, 999);
    if (recv_calm > 0) begin
      recv_calm--;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (roll < 10) begin
      recv_calm = $urandom_range(50, 400);
      m_axis_tready <= 1'b1;
    end else if (roll < 110) begin
      if (roll < 80) stall_left = $urandom_range(0, 2);
      else if (roll < 105) stall_left = $urandom_range(3, 14);
      else stall_left = $urandom_range(100, 400);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: model accepted requests, check delivered results
  always @(posedge clk) begin
    fir_res_t want;
    took_req <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) apply_request(drv_req);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_outs.size() == 0) begin
        $display("%0t: unexpected result, got sample_out %0d out_of_range %0b",
                 $time, $signed(m_axis_tdata[15:0]), m_axis_tuser);
        err_count++;
      end else begin
        want = expected_outs.pop_front();
        if (m_axis_tdata[15:0] !== want.sample_out) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, $signed(want.sample_out), $signed(m_axis_tdata[15:0]));
          err_count++;
        end
        if (m_axis_tuser !== want.out_of_range) begin
          $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                   $time, want.out_of_range, m_axis_tuser);
          err_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    tap_profile_t prof;
    int           n_phase;
    int           roll;

    for (int k = 0; k < NUM_TAPS; k++) begin
      hist[k]     = '0;
      coef_mem[k] = '0;
    end
    coef_bound = 16;

    // Directed: writes past the last tap are dropped, then two taps of -1.0
    push_tap(255, 16'h7FFF);
    push_tap(200, 16'h8000);
    push_tap(0, 16'h8000);
    push_tap(1, 16'h8000);
    for (int k = 2; k < NUM_TAPS; k++) push_tap(k, 16'h0000);
    push_tap(NUM_TAPS, 16'h1234);
    push_sample(16'h8000);   // sum exactly +1.0, saturates
    push_sample(16'h8000);   // +2.0, out of range
    push_sample(16'h4000);   // +0.5
    push_sample(16'h4000);   // sum exactly -1.0
    push_sample(16'h7FFF);
    push_sample(16'h7FFF);   // below -1.0, out of range
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    // tap rewrite mid-stream, then sums with dropped fraction bits
    push_tap(0, 16'h7FFF);
    push_sample(16'h0003);
    push_sample(16'hFFFD);
    push_tap(199, 16'h7FFF);
    push_sample(16'h8000);

    // Random phases: load a full tap set, then a run of samples with
    // occasional tap rewrites and dropped writes
    while (pending_reqs.size() < 1600) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) prof = PROF_SOFT;
      else if (roll < 7) prof = PROF_SPARSE;
      else prof = PROF_FULL;
      coef_bound = 1 << $urandom_range(4, 9);
      for (int k = 0; k < NUM_TAPS; k++) push_tap(k, rand_coef(prof));
      n_phase = $urandom_range(60, 250);
      repeat (n_phase) begin
        roll = $urandom_range(0, 99);
        if (roll < 90) push_sample(rand_sample());
        else if (roll < 97) push_tap($urandom_range(0, NUM_TAPS - 1), rand_coef(prof));
        else push_tap($urandom_range(NUM_TAPS, 255), 16'($urandom));
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_outs.size() != 0) @(posedge clk);
    repeat (NUM_TAPS + 40) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
